### src/bscl_pkg.sv
`timescale 1ns / 1ps

package bscl_pkg;

    // fixed field widths
    localparam int REQ_W   = 3;
    localparam int INDEX_W = 6;
    localparam int TOTAL_W = 7;
    localparam int POS_W   = 6;
    localparam int LEN_W   = 7;

    localparam int LENGTH_DEF = 64;
    localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;

    // request codes
    localparam logic [REQ_W-1:0] REQ_SET        = 3'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd1;
    localparam logic [REQ_W-1:0] REQ_GET        = 3'd2;
    localparam logic [REQ_W-1:0] REQ_COUNT      = 3'd3;
    localparam logic [REQ_W-1:0] REQ_LIST_ONES  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_LIST_ZEROS = 3'd5;

    typedef struct packed {
        logic load_req;    // latch a new request, clear cursor and counters
        logic single_do;   // perform set, clear or get and load its result
        logic scan_step;   // counting pass, one bit
        logic emit_final;  // load count result or empty list result
        logic list_start;  // rewind cursor for the emitting pass
        logic list_emit;   // load one list result and advance
        logic list_skip;   // advance past a non-matching bit
    } cmd_t;

    typedef struct packed {
        logic out_free;    // output register can take a result this cycle
        logic at_end;      // cursor reached the effective length
        logic cur_match;   // bit under cursor matches the request
        logic is_count;    // latched request is a count
        logic cnt_zero;    // counting pass found no match
        logic list_last;   // next list result is the final one
    } stat_t;

endpackage

### src/bscl_ctrl.sv
`timescale 1ns / 1ps

module bscl_ctrl
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [bscl_pkg::REQ_W-1:0]  in_req,
    output logic                        in_ready,
    input  bscl_pkg::stat_t             stat,
    output bscl_pkg::cmd_t              cmd
);

    typedef enum logic [3:0]
    {
        S_IDLE   = 4'b0001,
        S_SINGLE = 4'b0010,
        S_SCAN   = 4'b0100,
        S_LIST   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    if (in_req == bscl_pkg::REQ_SET || in_req == bscl_pkg::REQ_CLEAR ||
                        in_req == bscl_pkg::REQ_GET)
                    begin
                        state_next = S_SINGLE;
                    end
                    else if (in_req == bscl_pkg::REQ_COUNT ||
                             in_req == bscl_pkg::REQ_LIST_ONES ||
                             in_req == bscl_pkg::REQ_LIST_ZEROS)
                    begin
                        state_next = S_SCAN;
                    end
                    // unused codes are dropped
                end
            end
            S_SINGLE:
            begin
                if (stat.out_free)
                begin
                    cmd.single_do = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (!stat.at_end)
                begin
                    cmd.scan_step = 1'b1;
                end
                else if (stat.is_count || stat.cnt_zero)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit_final = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    cmd.list_start = 1'b1;
                    state_next     = S_LIST;
                end
            end
            S_LIST:
            begin
                if (stat.cur_match)
                begin
                    if (stat.out_free)
                    begin
                        cmd.list_emit = 1'b1;
                        if (stat.list_last)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
                else
                begin
                    cmd.list_skip = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### src/bscl_datapath.sv
`timescale 1ns / 1ps

module bscl_datapath
#(
    parameter int LENGTH = bscl_pkg::LENGTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bscl_pkg::LEN_W-1:0]    cfg_data,
    input  logic [bscl_pkg::REQ_W-1:0]    in_req,
    input  logic [bscl_pkg::INDEX_W-1:0]  in_index,
    input  bscl_pkg::cmd_t                cmd,
    output bscl_pkg::stat_t               stat,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic                          out_status,
    output logic                          out_bit_value,
    output logic [bscl_pkg::TOTAL_W-1:0]  out_total,
    output logic [bscl_pkg::POS_W-1:0]    out_position,
    output logic                          out_none_found,
    output logic                          out_last
);

    localparam int SEL_W = (LENGTH > 1) ? $clog2(LENGTH) : 1;
    localparam logic [bscl_pkg::LEN_W-1:0] LEN_MAX = bscl_pkg::LEN_W'(LENGTH);

    logic [LENGTH-1:0]                store_reg, store_next;
    logic [bscl_pkg::LEN_W-1:0]       len_reg;
    logic [bscl_pkg::REQ_W-1:0]       req_reg, req_next;
    logic [bscl_pkg::INDEX_W-1:0]     idx_reg, idx_next;
    logic [bscl_pkg::LEN_W-1:0]       cursor_reg, cursor_next;
    logic [bscl_pkg::TOTAL_W-1:0]     cnt_reg, cnt_next;
    logic [bscl_pkg::TOTAL_W-1:0]     k_reg, k_next;

    logic                             valid_reg, valid_next;
    logic                             status_reg, status_next;
    logic                             bitv_reg, bitv_next;
    logic [bscl_pkg::TOTAL_W-1:0]     total_reg, total_next;
    logic [bscl_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic                             none_reg, none_next;
    logic                             last_reg, last_next;

    logic [bscl_pkg::LEN_W-1:0]       n_eff;
    logic                             cur_bit;
    logic                             cur_sel;
    logic                             in_range;
    logic                             out_free;
    logic                             is_count;
    logic                             list_last;

    always_comb
    begin
        n_eff     = (len_reg > LEN_MAX) ? LEN_MAX : len_reg;
        cur_bit   = store_reg[cursor_reg[SEL_W-1:0]];
        cur_sel   = (req_reg == bscl_pkg::REQ_LIST_ZEROS) ? ~cur_bit : cur_bit;
        in_range  = bscl_pkg::LEN_W'(idx_reg) < n_eff;
        out_free  = !valid_reg || out_ready;
        is_count  = (req_reg == bscl_pkg::REQ_COUNT);
        list_last = ((k_reg + 7'd1) == cnt_reg);

        stat.out_free  = out_free;
        stat.at_end    = (cursor_reg >= n_eff);
        stat.cur_match = cur_sel;
        stat.is_count  = is_count;
        stat.cnt_zero  = (cnt_reg == '0);
        stat.list_last = list_last;
    end

    always_comb
    begin
        store_next  = store_reg;
        req_next    = req_reg;
        idx_next    = idx_reg;
        cursor_next = cursor_reg;
        cnt_next    = cnt_reg;
        k_next      = k_reg;
        status_next = status_reg;
        bitv_next   = bitv_reg;
        total_next  = total_reg;
        pos_next    = pos_reg;
        none_next   = none_reg;
        last_next   = last_reg;
        valid_next  = out_ready ? 1'b0 : valid_reg;

        if (cmd.load_req)
        begin
            req_next    = in_req;
            idx_next    = in_index;
            cursor_next = '0;
            cnt_next    = '0;
            k_next      = '0;
        end

        if (cmd.scan_step)
        begin
            cursor_next = cursor_reg + 7'd1;
            cnt_next    = cnt_reg + bscl_pkg::TOTAL_W'(cur_sel);
        end

        if (cmd.list_start)
        begin
            cursor_next = '0;
            k_next      = '0;
        end

        if (cmd.list_skip)
        begin
            cursor_next = cursor_reg + 7'd1;
        end

        if (cmd.single_do)
        begin
            valid_next  = 1'b1;
            status_next = !in_range;
            bitv_next   = in_range && (req_reg == bscl_pkg::REQ_GET) &&
                          store_reg[idx_reg[SEL_W-1:0]];
            total_next  = '0;
            pos_next    = '0;
            none_next   = 1'b0;
            last_next   = 1'b1;
            if (in_range && req_reg == bscl_pkg::REQ_SET)
            begin
                store_next[idx_reg[SEL_W-1:0]] = 1'b1;
            end
            if (in_range && req_reg == bscl_pkg::REQ_CLEAR)
            begin
                store_next[idx_reg[SEL_W-1:0]] = 1'b0;
            end
        end

        if (cmd.emit_final)
        begin
            valid_next  = 1'b1;
            status_next = 1'b0;
            bitv_next   = 1'b0;
            total_next  = is_count ? cnt_reg : '0;
            pos_next    = '0;
            none_next   = !is_count;
            last_next   = 1'b1;
        end

        if (cmd.list_emit)
        begin
            valid_next  = 1'b1;
            status_next = 1'b0;
            bitv_next   = 1'b0;
            total_next  = cnt_reg;
            pos_next    = bscl_pkg::POS_W'(cursor_reg[SEL_W-1:0]);
            none_next   = 1'b0;
            last_next   = list_last;
            k_next      = k_reg + 7'd1;
            cursor_next = cursor_reg + 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg  <= '0;
            len_reg    <= bscl_pkg::LEN_RESET;
            req_reg    <= '0;
            cursor_reg <= '0;
            cnt_reg    <= '0;
            k_reg      <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            store_reg  <= store_next;
            req_reg    <= req_next;
            cursor_reg <= cursor_next;
            cnt_reg    <= cnt_next;
            k_reg      <= k_next;
            valid_reg  <= valid_next;
            if (cfg_we)
            begin
                len_reg <= cfg_data;
            end
        end
    end

    // result payload and latched index, no reset
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        status_reg <= status_next;
        bitv_reg   <= bitv_next;
        total_reg  <= total_next;
        pos_reg    <= pos_next;
        none_reg   <= none_next;
        last_reg   <= last_next;
    end

    assign out_valid      = valid_reg;
    assign out_status     = status_reg;
    assign out_bit_value  = bitv_reg;
    assign out_total      = total_reg;
    assign out_position   = pos_reg;
    assign out_none_found = none_reg;
    assign out_last       = last_reg;

endmodule

### src/bitmap_set_clear_count_list_core.sv
`timescale 1ns / 1ps
// set, clear, get: accepted in idle, performed once the output register is free,
// result registered; no new request is taken until then. count, list: a single bit
// cursor walks the effective length once to count and, if a list has matches, once to emit
// reset: map all zeros, length_in_use 64, output empty
module bitmap_set_clear_count_list_core
#(
    parameter int LENGTH = bscl_pkg::LENGTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // req_type[2:0], bit_index[8:3], zeros
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // bit_value[0], total[7:1], position[13:8], zeros
    output logic [1:0]  m_tuser,   // status[0], none_found[1]
    output logic        m_tlast
);

    bscl_pkg::cmd_t  cmd;
    bscl_pkg::stat_t stat;

    logic                          out_status;
    logic                          out_bit_value;
    logic [bscl_pkg::TOTAL_W-1:0]  out_total;
    logic [bscl_pkg::POS_W-1:0]    out_position;
    logic                          out_none_found;

    bscl_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_req   (s_tdata[2:0]),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bscl_datapath #(
        .LENGTH (LENGTH)
    ) u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .in_req         (s_tdata[2:0]),
        .in_index       (s_tdata[8:3]),
        .cmd            (cmd),
        .stat           (stat),
        .out_ready      (m_tready),
        .out_valid      (m_tvalid),
        .out_status     (out_status),
        .out_bit_value  (out_bit_value),
        .out_total      (out_total),
        .out_position   (out_position),
        .out_none_found (out_none_found),
        .out_last       (m_tlast)
    );

    assign m_tdata = {2'b00, out_position, out_total, out_bit_value};
    assign m_tuser = {out_none_found, out_status};

endmodule

### dv/tb_bitmap_set_clear_count_list_core.sv
`timescale 1ns / 1ps

module tb_bitmap_set_clear_count_list_core;

    // request codes the block has to ignore
    localparam logic [bscl_pkg::REQ_W-1:0] REQ_UNUSED_6 = 3'd6;
    localparam logic [bscl_pkg::REQ_W-1:0] REQ_UNUSED_7 = 3'd7;

    localparam logic [bscl_pkg::LEN_W-1:0] LEN_REG_MAX = 7'd127;
    localparam int MAP_BITS   = 64;
    // a list walks the map twice, so this covers the longest request
    localparam int IDLE_TAIL  = 2 * MAP_BITS + 20;
    localparam int DRAIN_WAIT = 50000;

    typedef struct packed {
        logic                         status;
        logic                         bit_value;
        logic [bscl_pkg::TOTAL_W-1:0] total;
        logic [bscl_pkg::POS_W-1:0]   position;
        logic                         none_found;
        logic                         last;
    } answer_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        cfg_we   = 1'b0;
    logic [6:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // req_type[2:0], bit_index[8:3], zeros
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // bit_value[0], total[7:1], position[13:8], zeros
    logic [1:0]  m_tuser;         // status[0], none_found[1]
    logic        m_tlast;

    // shadow of the block state
    logic [MAP_BITS-1:0]        bitmap_model = '0;
    logic [bscl_pkg::LEN_W-1:0] len_reg      = bscl_pkg::LEN_RESET;

    answer_t answers_due[$];

    int error_count     = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int burst_left      = 0;
    int stall_mode      = 0;
    int stall_tick      = 0;

    bitmap_set_clear_count_list_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int active_length();
        return (len_reg > MAP_BITS) ? MAP_BITS : int'(len_reg);
    endfunction

    function automatic logic [MAP_BITS-1:0] in_use_mask(input int n);
        if (n >= MAP_BITS)
            return '1;
        return (64'd1 << n) - 64'd1;
    endfunction

    function automatic int bit_sum(input logic [MAP_BITS-1:0] v);
        int c;
        c = 0;
        for (int i = 0; i < MAP_BITS; i++)
            c += v[i];
        return c;
    endfunction

    // work out the answers of one accepted request and update the shadow map
    task automatic predict_answers(input logic [bscl_pkg::REQ_W-1:0] req,
                                   input logic [bscl_pkg::INDEX_W-1:0] idx);
        int                  n;
        int                  hit_total;
        int                  k;
        logic [MAP_BITS-1:0] picked;
        answer_t             a;
        n = active_length();
        a = '0;
        a.last = 1'b1;
        case (req)
            bscl_pkg::REQ_SET, bscl_pkg::REQ_CLEAR, bscl_pkg::REQ_GET:
            begin
                if (int'(idx) >= n)
                    a.status = 1'b1;
                else if (req == bscl_pkg::REQ_SET)
                    bitmap_model[idx] = 1'b1;
                else if (req == bscl_pkg::REQ_CLEAR)
                    bitmap_model[idx] = 1'b0;
                else
                    a.bit_value = bitmap_model[idx];
                answers_due.push_back(a);
            end
            bscl_pkg::REQ_COUNT:
            begin
                a.total = bscl_pkg::TOTAL_W'(bit_sum(bitmap_model & in_use_mask(n)));
                answers_due.push_back(a);
            end
            bscl_pkg::REQ_LIST_ONES, bscl_pkg::REQ_LIST_ZEROS:
            begin
                picked = (req == bscl_pkg::REQ_LIST_ONES) ? bitmap_model : ~bitmap_model;
                picked &= in_use_mask(n);
                hit_total = bit_sum(picked);
                if (hit_total == 0)
                begin
                    a.none_found = 1'b1;
                    answers_due.push_back(a);
                end
                else
                begin
                    k = 0;
                    for (int i = 0; i < n; i++)
                    begin
                        if (picked[i])
                        begin
                            a.total    = bscl_pkg::TOTAL_W'(hit_total);
                            a.position = bscl_pkg::POS_W'(i);
                            a.last     = (k + 1 == hit_total);
                            answers_due.push_back(a);
                            k++;
                        end
                    end
                end
            end
            default:
                ;
        endcase
    endtask

    task automatic send_request(input logic [bscl_pkg::REQ_W-1:0] req,
                                input logic [bscl_pkg::INDEX_W-1:0] idx);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, idx, req};
        do
            @(posedge clk);
        while (!s_tready);
        predict_answers(req, idx);
        items_sent++;
    endtask

    task automatic wait_until_idle();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (answers_due.size() != 0 && guard < DRAIN_WAIT)
        begin
            @(posedge clk);
            guard++;
        end
        if (answers_due.size() != 0)
        begin
            $error("%0d results never arrived", answers_due.size());
            error_count++;
            answers_due.delete();
        end
        // ignored requests leave nothing to wait for, so give the block time
        repeat (IDLE_TAIL) @(posedge clk);
    endtask

    task automatic write_length(input logic [bscl_pkg::LEN_W-1:0] v);
        wait_until_idle();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        len_reg = v;
        cfg_we  <= 1'b0;
    endtask

    task automatic test_after_reset();
        send_request(bscl_pkg::REQ_COUNT, 6'd0);
        send_request(bscl_pkg::REQ_LIST_ONES, 6'd0);
        send_request(bscl_pkg::REQ_LIST_ZEROS, 6'd63);
        send_request(bscl_pkg::REQ_GET, 6'd63);
    endtask

    task automatic test_single_access();
        send_request(bscl_pkg::REQ_SET, 6'd0);
        send_request(bscl_pkg::REQ_SET, 6'd63);
        send_request(bscl_pkg::REQ_GET, 6'd0);
        send_request(bscl_pkg::REQ_GET, 6'd63);
        send_request(bscl_pkg::REQ_CLEAR, 6'd0);
        send_request(bscl_pkg::REQ_GET, 6'd0);
        send_request(REQ_UNUSED_6, 6'd63);
        send_request(REQ_UNUSED_7, 6'd0);
        send_request(bscl_pkg::REQ_COUNT, 6'd0);
        send_request(bscl_pkg::REQ_LIST_ONES, 6'd0);
    endtask

    task automatic test_length_register();
        // nothing in use
        write_length(7'd0);
        send_request(bscl_pkg::REQ_SET, 6'd0);
        send_request(bscl_pkg::REQ_COUNT, 6'd0);
        send_request(bscl_pkg::REQ_LIST_ZEROS, 6'd0);
        // one bit in use
        write_length(7'd1);
        send_request(bscl_pkg::REQ_SET, 6'd0);
        send_request(bscl_pkg::REQ_LIST_ZEROS, 6'd0);
        send_request(bscl_pkg::REQ_GET, 6'd1);
        // above the map size saturates
        write_length(LEN_REG_MAX);
        send_request(bscl_pkg::REQ_GET, 6'd63);
        // bit 63 stays stored but hidden
        write_length(7'd10);
        send_request(bscl_pkg::REQ_GET, 6'd63);
        send_request(bscl_pkg::REQ_COUNT, 6'd0);
        write_length(bscl_pkg::LEN_RESET);
        send_request(bscl_pkg::REQ_GET, 6'd63);
    endtask

    task automatic test_random_traffic();
        logic [bscl_pkg::LEN_W-1:0]   lengths[7];
        int                           pick;
        int                           n;
        logic [bscl_pkg::REQ_W-1:0]   req;
        logic [bscl_pkg::INDEX_W-1:0] idx;
        lengths = '{7'd64, 7'd1, LEN_REG_MAX, 7'd0,
                    bscl_pkg::LEN_W'($urandom_range(2, 63)), 7'd65,
                    bscl_pkg::LEN_W'($urandom_range(0, 127))};
        foreach (lengths[p])
        begin
            write_length(lengths[p]);
            n = active_length();
            repeat (14)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 30)
                    req = bscl_pkg::REQ_SET;
                else if (pick < 45)
                    req = bscl_pkg::REQ_CLEAR;
                else if (pick < 70)
                    req = bscl_pkg::REQ_GET;
                else if (pick < 78)
                    req = bscl_pkg::REQ_COUNT;
                else if (pick < 86)
                    req = bscl_pkg::REQ_LIST_ONES;
                else if (pick < 94)
                    req = bscl_pkg::REQ_LIST_ZEROS;
                else if (pick < 97)
                    req = REQ_UNUSED_6;
                else
                    req = REQ_UNUSED_7;
                // mostly in range, now and then anywhere
                if (n > 0 && $urandom_range(0, 99) < 85)
                    idx = bscl_pkg::INDEX_W'($urandom_range(0, n - 1));
                else
                    idx = bscl_pkg::INDEX_W'($urandom_range(0, 63));
                send_request(req, idx);
            end
        end
    endtask

    always @(posedge clk)
    begin : result_check
        answer_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (answers_due.size() == 0)
            begin
                $error("result with none due: tdata %h tuser %b tlast %b",
                       m_tdata, m_tuser, m_tlast);
                error_count++;
            end
            else
            begin
                want = answers_due.pop_front();
                results_checked++;
                if (m_tuser[0] !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser[0]);
                    error_count++;
                end
                if (m_tdata[0] !== want.bit_value)
                begin
                    $error("bit_value: expected %0d, got %0d", want.bit_value, m_tdata[0]);
                    error_count++;
                end
                if (m_tdata[7:1] !== want.total)
                begin
                    $error("total: expected %0d, got %0d", want.total, m_tdata[7:1]);
                    error_count++;
                end
                if (m_tdata[13:8] !== want.position)
                begin
                    $error("position: expected %0d, got %0d", want.position, m_tdata[13:8]);
                    error_count++;
                end
                if (m_tuser[1] !== want.none_found)
                begin
                    $error("none_found: expected %0d, got %0d", want.none_found, m_tuser[1]);
                    error_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, m_tlast);
                    error_count++;
                end
            end
        end
        // receiver picks a new stall pattern at random each time stall_tick wraps
        stall_tick++;
        if (stall_tick >= 48)
        begin
            stall_tick = 0;
            stall_mode = $urandom_range(0, 3);
        end
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= (stall_tick % 4 == 0);
            default: m_tready <= 1'($urandom_range(0, 1));
        endcase
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_after_reset();
        test_single_access();
        test_length_register();
        test_random_traffic();
        wait_until_idle();
        $display("run covered %0d requests and %0d checked results", items_sent,
                 results_checked);
        $display("all request kinds, unused codes, lengths 0 to 127 with saturation");
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
